>>> sv/fri_pkg.sv
// fri_pkg: shared types, codes and arithmetic helpers of the field receiver interpolator.
// Used by fri_div, fri_dp, fri_ctrl and the top level. No dependencies.
package fri_pkg;

	localparam int DATA_W  = 32;
	localparam int WGT_W   = 16;
	localparam int RHO_W   = 24;
	localparam int ACC_W   = 64;
	localparam int FUNC_W  = 2;
	localparam int SCALE_RE_RST = 32'h4000_0000;
	localparam int SCALE_IM_RST = 32'h0000_0000;

	// Mode codes
	localparam logic [FUNC_W-1:0] FUNC_PLAIN = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_VERT  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_MAG   = 2'd2;

	// Register indexes
	localparam logic REG_SCALE_RE = 1'b0;
	localparam logic REG_SCALE_IM = 1'b1;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_MUL_AB, CMD_MUL_C, CMD_W14, CMD_FAULT,
		CMD_DIV_G, CMD_G, CMD_MUL_RE, CMD_ACC_RE, CMD_MUL_IM, CMD_ACC_IM,
		CMD_ZSAT, CMD_DIV_RE, CMD_RAT_RE, CMD_DIV_IM, CMD_RAT_IM, CMD_RND14,
		CMD_MUL_P1, CMD_SET_T, CMD_MUL_P2, CMD_SUB_T, CMD_MUL_P3, CMD_SET_U,
		CMD_MUL_P4, CMD_ADD_U, CMD_RND30, CMD_OUT
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE, S_MAB, S_MC, S_W14, S_FLT, S_DIVG, S_WDG, S_G, S_MRE, S_ARE,
		S_MIM, S_AIM, S_TAIL, S_ZSAT, S_DRE, S_WDRE, S_RRE, S_DIM, S_WDIM,
		S_RIM, S_R14, S_M1, S_A1, S_M2, S_A2, S_M3, S_A3, S_M4, S_A4, S_R30,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              last;
		logic              rho_zero;
		logic              wt_zero;
		logic              div_done;
		logic              out_free;
	} status_t;

	// Add with saturation at the 64-bit signed range
	function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s[ACC_W-1:0];
	endfunction

	// Clamp to the 32-bit signed range
	function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF) return 32'h7FFF_FFFF;
		if (v < -64'sh0000_0000_8000_0000) return 32'h8000_0000;
		return v[DATA_W-1:0];
	endfunction

	// Round half up by 2^n with a saturating bias add, then clamp to 32 bits
	function automatic logic [DATA_W-1:0] rnd_sat32(input logic signed [ACC_W-1:0] v,
		input int n);
		logic signed [ACC_W-1:0] t;
		t = sat_add64(v, $signed(64'd1 << (n - 1)));
		return sat32(t >>> n);
	endfunction

endpackage

>>> sv/fri_div.sv
// fri_div: iterative unsigned divider, one quotient bit per cycle.
// Depends on fri_pkg for the operand width.
module fri_div
	import fri_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] num,
	input  logic [ACC_W-1:0] den,
	output logic             done,
	output logic [ACC_W-1:0] quo,
	output logic [ACC_W-1:0] rem
);
	localparam int CNT_W = $clog2(ACC_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] quo_q;
	logic [ACC_W-1:0] rem_q;
	logic [ACC_W-1:0] den_q;
	logic [ACC_W:0]   trial;
	logic [ACC_W:0]   diff;

	// Shift in the next numerator bit and try the subtract
	assign trial = {rem_q, quo_q[ACC_W-1]};
	assign diff  = trial - {1'b0, den_q};

	// Count the remaining steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (start)
			cnt_q <= CNT_W'(ACC_W);
		else if (cnt_q != '0)
			cnt_q <= cnt_q - 1'b1;
	end

	// Advance the partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!diff[ACC_W]) begin
				rem_q <= diff[ACC_W-1:0];
				quo_q <= {quo_q[ACC_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[ACC_W-1:0];
				quo_q <= {quo_q[ACC_W-2:0], 1'b0};
			end
		end
	end

	assign done = (cnt_q == '0);
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

>>> sv/fri_dp.sv
// fri_dp: datapath with tap registers, shared multiplier, accumulators,
// configuration registers and the output register. Depends on fri_pkg and fri_div.
module fri_dp
	import fri_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output status_t                  sts,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] sample_re,
	input  logic signed [DATA_W-1:0] sample_im,
	input  logic signed [WGT_W-1:0]  weight_a,
	input  logic signed [WGT_W-1:0]  weight_b,
	input  logic signed [WGT_W-1:0]  weight_c,
	input  logic [RHO_W-1:0]         resistivity,
	input  logic                     last_tap,
	input  logic                     wr_en,
	input  logic                     wr_index,
	input  logic [DATA_W-1:0]        wr_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] result_re,
	output logic signed [DATA_W-1:0] result_im,
	output logic                     fault
);
	logic [FUNC_W-1:0]        func_q;
	logic signed [DATA_W-1:0] sre_q, sim_q;
	logic signed [WGT_W-1:0]  wa_q, wb_q, wc_q;
	logic [RHO_W-1:0]         rho_q;
	logic                     last_q;
	logic signed [ACC_W-1:0]  prod_q;
	logic signed [DATA_W-1:0] w_q;
	logic signed [ACC_W-1:0]  sum_re_q, sum_im_q, wt_q;
	logic                     fault_q;
	logic signed [ACC_W-1:0]  t_q, u_q;
	logic signed [DATA_W-1:0] res_re_q, res_im_q;
	logic signed [DATA_W-1:0] scale_re_q, scale_im_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_re_q, out_im_q;
	logic                     out_fault_q;

	logic signed [DATA_W-1:0] mul_a, mul_b;
	logic signed [ACC_W-1:0]  mul_p;
	logic signed [ACC_W-1:0]  w_rnd;
	logic [DATA_W-1:0]        w_abs;
	logic                     div_start, div_done;
	logic [ACC_W-1:0]         div_num, div_den, div_quo, div_rem;

	function automatic logic [ACC_W-1:0] abs64(input logic signed [ACC_W-1:0] v);
		return v[ACC_W-1] ? (ACC_W'(0) - v) : v;
	endfunction

	// Round the quotient to nearest, halves away from zero, and clamp
	function automatic logic [DATA_W-1:0] ratio_fin(input logic [ACC_W-1:0] q,
		input logic [ACC_W-1:0] r, input logic [ACC_W-1:0] md, input logic neg);
		logic [ACC_W-1:0] qq;
		qq = q + ((r >= md - r) ? ACC_W'(1) : ACC_W'(0));
		if (neg) begin
			if (qq > 64'h0000_0000_8000_0000) return 32'h8000_0000;
			return DATA_W'(ACC_W'(0) - qq);
		end
		if (qq > 64'h0000_0000_7FFF_FFFF) return 32'h7FFF_FFFF;
		return qq[DATA_W-1:0];
	endfunction

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd)
			CMD_MUL_AB: begin mul_a = DATA_W'(wa_q); mul_b = DATA_W'(wb_q); end
			CMD_MUL_C:  begin mul_a = prod_q[DATA_W-1:0]; mul_b = DATA_W'(wc_q); end
			CMD_MUL_RE: begin mul_a = sre_q; mul_b = w_q; end
			CMD_MUL_IM: begin mul_a = sim_q; mul_b = w_q; end
			CMD_MUL_P1: begin mul_a = res_re_q; mul_b = scale_re_q; end
			CMD_MUL_P2: begin mul_a = res_im_q; mul_b = scale_im_q; end
			CMD_MUL_P3: begin mul_a = res_re_q; mul_b = scale_im_q; end
			CMD_MUL_P4: begin mul_a = res_im_q; mul_b = scale_re_q; end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;
	assign w_rnd = (prod_q + 64'sd134217728) >>> 28;
	assign w_abs = w_q[DATA_W-1] ? (DATA_W'(0) - w_q) : w_q;

	// Select divider operands
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd)
			CMD_DIV_G: begin
				div_start = 1'b1;
				div_num   = ACC_W'(w_abs) << 12;
				div_den   = ACC_W'(rho_q);
			end
			CMD_DIV_RE: begin
				div_start = 1'b1;
				div_num   = abs64(sum_re_q);
				div_den   = abs64(wt_q);
			end
			CMD_DIV_IM: begin
				div_start = 1'b1;
				div_num   = abs64(sum_im_q);
				div_den   = abs64(wt_q);
			end
			default: ;
		endcase
	end

	fri_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// Hold configuration and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_re_q  <= SCALE_RE_RST;
			scale_im_q  <= SCALE_IM_RST;
			sum_re_q    <= '0;
			sum_im_q    <= '0;
			wt_q        <= '0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_SCALE_RE: scale_re_q <= wr_data;
					REG_SCALE_IM: scale_im_q <= wr_data;
				endcase
			end
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (cmd)
				CMD_FAULT, CMD_ZSAT: fault_q <= 1'b1;
				CMD_ACC_RE: sum_re_q <= sat_add64(sum_re_q, prod_q);
				CMD_ACC_IM: begin
					sum_im_q <= sat_add64(sum_im_q, prod_q);
					if (func_q == FUNC_VERT)
						wt_q <= sat_add64(wt_q, ACC_W'(w_q));
				end
				CMD_OUT: begin
					out_valid_q <= 1'b1;
					sum_re_q    <= '0;
					sum_im_q    <= '0;
					wt_q        <= '0;
					fault_q     <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Tap payload and working registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				func_q <= func;
				sre_q  <= sample_re;
				sim_q  <= sample_im;
				wa_q   <= weight_a;
				wb_q   <= weight_b;
				wc_q   <= weight_c;
				rho_q  <= resistivity;
				last_q <= last_tap;
			end
			CMD_MUL_AB, CMD_MUL_C, CMD_MUL_RE, CMD_MUL_IM,
			CMD_MUL_P1, CMD_MUL_P2, CMD_MUL_P3, CMD_MUL_P4: prod_q <= mul_p;
			CMD_W14: w_q <= w_rnd[DATA_W-1:0];
			CMD_G: w_q <= w_q[DATA_W-1] ? (DATA_W'(0) - div_quo[DATA_W-1:0])
				: div_quo[DATA_W-1:0];
			CMD_ZSAT: begin
				res_re_q <= (sum_re_q > 0) ? 32'sh7FFF_FFFF
					: (sum_re_q < 0) ? 32'sh8000_0000 : 32'sh0;
				res_im_q <= (sum_im_q > 0) ? 32'sh7FFF_FFFF
					: (sum_im_q < 0) ? 32'sh8000_0000 : 32'sh0;
			end
			CMD_RAT_RE: res_re_q <= ratio_fin(div_quo, div_rem, abs64(wt_q),
				sum_re_q[ACC_W-1] ^ wt_q[ACC_W-1]);
			CMD_RAT_IM: res_im_q <= ratio_fin(div_quo, div_rem, abs64(wt_q),
				sum_im_q[ACC_W-1] ^ wt_q[ACC_W-1]);
			CMD_RND14: begin
				res_re_q <= rnd_sat32(sum_re_q, 14);
				res_im_q <= rnd_sat32(sum_im_q, 14);
			end
			CMD_SET_T: t_q <= prod_q;
			CMD_SUB_T: t_q <= sat_add64(t_q, -prod_q);
			CMD_SET_U: u_q <= prod_q;
			CMD_ADD_U: u_q <= sat_add64(u_q, prod_q);
			CMD_RND30: begin
				res_re_q <= rnd_sat32(t_q, 30);
				res_im_q <= rnd_sat32(u_q, 30);
			end
			CMD_OUT: begin
				out_re_q    <= res_re_q;
				out_im_q    <= res_im_q;
				out_fault_q <= fault_q;
			end
			default: ;
		endcase
	end

	// Status toward the controller
	always_comb begin
		sts.func     = func_q;
		sts.last     = last_q;
		sts.rho_zero = (rho_q == '0);
		sts.wt_zero  = (wt_q == '0);
		sts.div_done = div_done;
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign result_re = out_re_q;
	assign result_im = out_im_q;
	assign fault     = out_fault_q;
endmodule

>>> sv/fri_ctrl.sv
// fri_ctrl: controller state machine that sequences the datapath per tap.
// Depends on fri_pkg for the state, command and status types.
module fri_ctrl
	import fri_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t sts,
	output cmd_t    cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_MAB;
			S_MAB:  state_d = S_MC;
			S_MC:   state_d = S_W14;
			S_W14: begin
				if (sts.func != FUNC_VERT) state_d = S_MRE;
				else if (sts.rho_zero)     state_d = S_FLT;
				else                       state_d = S_DIVG;
			end
			S_FLT:  state_d = S_TAIL;
			S_DIVG: state_d = S_WDG;
			S_WDG:  if (sts.div_done) state_d = S_G;
			S_G:    state_d = S_MRE;
			S_MRE:  state_d = S_ARE;
			S_ARE:  state_d = S_MIM;
			S_MIM:  state_d = S_AIM;
			S_AIM:  state_d = S_TAIL;
			S_TAIL: begin
				if (!sts.last)                state_d = S_IDLE;
				else if (sts.func != FUNC_VERT) state_d = S_R14;
				else if (sts.wt_zero)         state_d = S_ZSAT;
				else                          state_d = S_DRE;
			end
			S_ZSAT: state_d = S_OUT;
			S_DRE:  state_d = S_WDRE;
			S_WDRE: if (sts.div_done) state_d = S_RRE;
			S_RRE:  state_d = S_DIM;
			S_DIM:  state_d = S_WDIM;
			S_WDIM: if (sts.div_done) state_d = S_RIM;
			S_RIM:  state_d = S_OUT;
			S_R14:  state_d = (sts.func == FUNC_MAG) ? S_M1 : S_OUT;
			S_M1:   state_d = S_A1;
			S_A1:   state_d = S_M2;
			S_M2:   state_d = S_A2;
			S_A2:   state_d = S_M3;
			S_M3:   state_d = S_A3;
			S_A3:   state_d = S_M4;
			S_M4:   state_d = S_A4;
			S_A4:   state_d = S_R30;
			S_R30:  state_d = S_OUT;
			S_OUT:  if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = CMD_NONE;
		unique case (state_q)
			S_IDLE: cmd = in_valid ? CMD_LOAD : CMD_NONE;
			S_MAB:  cmd = CMD_MUL_AB;
			S_MC:   cmd = CMD_MUL_C;
			S_W14:  cmd = CMD_W14;
			S_FLT:  cmd = CMD_FAULT;
			S_DIVG: cmd = CMD_DIV_G;
			S_G:    cmd = CMD_G;
			S_MRE:  cmd = CMD_MUL_RE;
			S_ARE:  cmd = CMD_ACC_RE;
			S_MIM:  cmd = CMD_MUL_IM;
			S_AIM:  cmd = CMD_ACC_IM;
			S_ZSAT: cmd = CMD_ZSAT;
			S_DRE:  cmd = CMD_DIV_RE;
			S_RRE:  cmd = CMD_RAT_RE;
			S_DIM:  cmd = CMD_DIV_IM;
			S_RIM:  cmd = CMD_RAT_IM;
			S_R14:  cmd = CMD_RND14;
			S_M1:   cmd = CMD_MUL_P1;
			S_A1:   cmd = CMD_SET_T;
			S_M2:   cmd = CMD_MUL_P2;
			S_A2:   cmd = CMD_SUB_T;
			S_M3:   cmd = CMD_MUL_P3;
			S_A3:   cmd = CMD_SET_U;
			S_M4:   cmd = CMD_MUL_P4;
			S_A4:   cmd = CMD_ADD_U;
			S_R30:  cmd = CMD_RND30;
			S_OUT:  cmd = sts.out_free ? CMD_OUT : CMD_NONE;
			S_WDG, S_WDRE, S_WDIM, S_TAIL: cmd = CMD_NONE;
			default: cmd = CMD_NONE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
endmodule

>>> sv/field_receiver_interpolator.sv
// Field receiver interpolator: one grid tap per beat, one result on the last tap.
// Modes 0/2/3 run the weight and accumulate steps per tap; mode 1 adds a 64-step divide for w/rho.
// The last tap adds rounding (mode 0), rounding and scaling (mode 2) or two 64-step
// divides in the shared divider (mode 1); a held result may wait while the next tap enters.
// Asynchronous active-low reset clears accumulators, internal fault, output valid; loads scale reset values.
module field_receiver_interpolator
	import fri_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] sample_re,
	input  logic signed [DATA_W-1:0] sample_im,
	input  logic signed [WGT_W-1:0]  weight_a,
	input  logic signed [WGT_W-1:0]  weight_b,
	input  logic signed [WGT_W-1:0]  weight_c,
	input  logic [RHO_W-1:0]         resistivity,
	input  logic                     last_tap,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] result_re,
	output logic signed [DATA_W-1:0] result_im,
	output logic                     fault,
	input  logic                     wr_en,
	input  logic                     wr_index,
	input  logic [DATA_W-1:0]        wr_data
);
	cmd_t    cmd;
	status_t sts;

	fri_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fri_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.sample_re   (sample_re),
		.sample_im   (sample_im),
		.weight_a    (weight_a),
		.weight_b    (weight_b),
		.weight_c    (weight_c),
		.resistivity (resistivity),
		.last_tap    (last_tap),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_re   (result_re),
		.result_im   (result_im),
		.fault       (fault)
	);
endmodule

>>> sv/fri_checker.sv
// fri_checker: port-level assertions for the field receiver interpolator.
// Depends on field_receiver_interpolator; attached by the bind below.
module fri_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result_re
);
	// One tap at a time: stall right after a beat is taken
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepted beat");

	// A result only appears while a tap is being worked on
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a tap in flight");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_re))
		else $error("stalled result changed");
endmodule

bind field_receiver_interpolator fri_checker u_fri_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result_re (result_re)
);
